>>> design/bfpa_pkg.sv
package bfpa_pkg;

  localparam int IDX_W  = 10;  // wide enough for any extent index
  localparam int NEED_W = 12;  // (bytes + 4) rounded up to 32-byte units

  typedef enum logic [1:0] {
    OP_REINIT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_DEFRAG = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    C_HOLD,
    C_ROT,   // every cell takes its right neighbor, cell 0 wraps to the end
    C_SHL,   // cells at or above idx take their right neighbor (drop idx)
    C_SHR,   // every cell takes its left neighbor, cell 0 takes the broadcast
    C_SET,   // cell idx loads the broadcast units
    C_INIT   // back to the reset contents
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   idx;
  } cell_cmd_t;

endpackage

>>> design/bfpa_cell.sv
module bfpa_cell #(
  parameter int SW        = 10,
  parameter int UW        = 11,
  parameter int RST_UNITS = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bfpa_pkg::cell_cmd_t       cmd_i,
  input  logic [bfpa_pkg::IDX_W-1:0] my_idx_i,
  input  logic [UW-1:0]             val_units_i,
  input  logic [SW-1:0]             left_start_i,
  input  logic [UW-1:0]             left_units_i,
  input  logic [SW-1:0]             right_start_i,
  input  logic [UW-1:0]             right_units_i,
  output logic [SW-1:0]             start_o,
  output logic [UW-1:0]             units_o
);
  import bfpa_pkg::*;

  logic [SW-1:0] start_q;
  logic [UW-1:0] units_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      units_q <= UW'(RST_UNITS);
    end else begin
      unique case (cmd_i.op)
        C_HOLD: ;
        C_ROT: begin
          start_q <= right_start_i;
          units_q <= right_units_i;
        end
        C_SHL: begin
          if (my_idx_i >= cmd_i.idx) begin
            start_q <= right_start_i;
            units_q <= right_units_i;
          end
        end
        C_SHR: begin
          start_q <= left_start_i;
          units_q <= left_units_i;
        end
        C_SET: begin
          if (my_idx_i == cmd_i.idx) units_q <= val_units_i;
        end
        C_INIT: begin
          start_q <= '0;
          units_q <= UW'(RST_UNITS);
        end
        default: ;
      endcase
    end
  end

  assign start_o = start_q;
  assign units_o = units_q;

endmodule

>>> design/best_fit_pool_allocator.sv
// Best-fit pool allocator over POOL_UNITS units of 32 bytes.
// Input beats on s_axis carry an opcode in tuser (reinit, alloc, free,
// defragment) and the byte count / block address in tdata. Every beat
// produces exactly one result beat on m_axis: address in tdata, status in
// tuser, units still free in the upper tdata bits.
// The free-extent list lives in a row of MAX_EXTENTS cells. A list walk
// rotates the whole row once through cell 0. Reinit needs no walk; alloc
// walks the list once; free reads the size table first, then walks once;
// defragment walks the list twice per extent checked and restarts from
// the head after each merge.
// One item is worked on at a time; s_axis_tready is high only when idle.
// The result register frees the input side: a new beat is taken while the
// previous result still waits, but the block then holds its next result
// until m_axis_tready drains the first.
// Reset leaves one extent covering the whole pool; the size table is not
// cleared.
module best_fit_pool_allocator #(
  parameter int POOL_UNITS  = 1024,
  parameter int MAX_EXTENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] request_bytes, [30:16] block_address
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [14:0] result_address, [25:15] free_units
  output logic [1:0]  m_axis_tuser   // [1:0] status
);
  import bfpa_pkg::*;

  localparam int SW = (POOL_UNITS > 1) ? $clog2(POOL_UNITS) : 1;
  localparam int UW = $clog2(POOL_UNITS + 1);
  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int VW = (UW > NEED_W) ? UW : NEED_W;
  localparam int EW = UW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MRD, S_FCHK, S_SCAN, S_ACT, S_DA, S_DB, S_DMRG, S_DDROP, S_DONE
  } state_e;

  function automatic logic [UW-1:0] sat_add(input logic [UW-1:0] a, input logic [UW-1:0] b);
    logic [EW-1:0] s;
    s = EW'(a) + EW'(b);
    return (s > EW'(POOL_UNITS)) ? UW'(POOL_UNITS) : UW'(s);
  endfunction

  state_e              state_q;
  op_e                 op_q;
  logic [NEED_W-1:0]   need_q;
  logic [SW-1:0]       unit_q;
  logic [CW-1:0]       k_q, count_q;
  logic [UW-1:0]       ft_q;
  logic                found_q, exact_q;
  logic [IW-1:0]       idx_q, i_q, j_q;
  logic [SW-1:0]       cap_s_q;
  logic [UW-1:0]       cap_u_q, ju_q;
  logic [EW-1:0]       end_q;
  logic [14:0]         res_addr_q;
  status_e             res_st_q;
  logic                m_valid_q;
  logic [14:0]         m_addr_q;
  logic [1:0]          m_st_q;
  logic [10:0]         m_free_q;

  // size table
  logic [UW-1:0] blk_mem [POOL_UNITS];
  logic [UW-1:0] blk_rd_q;
  logic          mem_we;
  logic [SW-1:0] mem_wa;
  logic [UW-1:0] mem_wd;

  // cell row
  cell_cmd_t     cmd;
  logic [UW-1:0] val_units;
  logic [SW-1:0] val_start;
  logic [SW-1:0] c_start [MAX_EXTENTS];
  logic [UW-1:0] c_units [MAX_EXTENTS];

  logic        accept;
  op_e         in_op;
  logic [15:0] in_bytes;
  logic [14:0] in_addr;
  logic [14:0] in_off;
  logic [9:0]  in_unit;
  logic        in_unit_ok;

  logic [SW-1:0] h_start;
  logic [UW-1:0] h_units;
  logic          k_live, k_last;
  logic [UW-1:0] carve_u;
  logic [EW-1:0] carve_s;
  logic [EW-1:0] alloc_s;
  logic          alloc_ok;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_op    = op_e'(s_axis_tuser);
  assign in_bytes = s_axis_tdata[15:0];
  assign in_addr  = s_axis_tdata[30:16];
  assign in_off   = in_addr - 15'd4;
  assign in_unit  = in_off[14:5];
  assign in_unit_ok = (in_addr >= 15'd4) && (in_off[4:0] == 5'd0) &&
                      (32'(in_unit) < 32'(POOL_UNITS));

  assign h_start = c_start[0];
  assign h_units = c_units[0];
  assign k_live  = k_q < count_q;
  assign k_last  = k_q == CW'(MAX_EXTENTS - 1);

  assign carve_u  = UW'(VW'(cap_u_q) - VW'(need_q));
  assign carve_s  = EW'(cap_s_q) + EW'(carve_u);
  assign alloc_s  = exact_q ? EW'(cap_s_q) : carve_s;
  assign alloc_ok = exact_q || found_q;

  genvar g;
  generate
    for (g = 0; g < MAX_EXTENTS; g++) begin : g_cell
      localparam int R = (g == MAX_EXTENTS - 1) ? 0 : g + 1;
      localparam int L = (g == 0) ? 0 : g - 1;
      logic [SW-1:0] ls;
      logic [UW-1:0] lu;
      assign ls = (g == 0) ? val_start : c_start[L];
      assign lu = (g == 0) ? val_units : c_units[L];
      bfpa_cell #(
        .SW(SW), .UW(UW), .RST_UNITS((g == 0) ? POOL_UNITS : 0)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .cmd_i        (cmd),
        .my_idx_i     (IDX_W'(g)),
        .val_units_i  (val_units),
        .left_start_i (ls),
        .left_units_i (lu),
        .right_start_i(c_start[R]),
        .right_units_i(c_units[R]),
        .start_o      (c_start[g]),
        .units_o      (c_units[g])
      );
    end
  endgenerate

  // cell commands and table writes
  always_comb begin
    cmd.op    = C_HOLD;
    cmd.idx   = '0;
    val_units = '0;
    val_start = unit_q;
    mem_we    = 1'b0;
    mem_wa    = unit_q;
    mem_wd    = '0;
    priority case (state_q)
      S_IDLE: if (accept && in_op == OP_REINIT) cmd.op = C_INIT;
      S_SCAN, S_DA, S_DB: cmd.op = C_ROT;
      S_ACT: begin
        if (op_q == OP_ALLOC) begin
          if (exact_q) begin
            cmd.op  = C_SHL;
            cmd.idx = IDX_W'(idx_q);
          end else if (found_q) begin
            cmd.op    = C_SET;
            cmd.idx   = IDX_W'(idx_q);
            val_units = carve_u;
          end
          if (alloc_ok && alloc_s < EW'(POOL_UNITS)) begin
            mem_we = 1'b1;
            mem_wa = SW'(alloc_s);
            mem_wd = UW'(need_q);
          end
        end else begin
          if (found_q) begin
            cmd.op    = C_SET;
            cmd.idx   = IDX_W'(idx_q);
            val_units = sat_add(cap_u_q, blk_rd_q);
            mem_we    = 1'b1;
          end else if (count_q < CW'(MAX_EXTENTS)) begin
            cmd.op    = C_SHR;
            val_units = blk_rd_q;
            mem_we    = 1'b1;
          end
        end
      end
      S_DMRG: begin
        cmd.op    = C_SET;
        cmd.idx   = IDX_W'(i_q);
        val_units = sat_add(cap_u_q, ju_q);
      end
      S_DDROP: begin
        cmd.op  = C_SHL;
        cmd.idx = IDX_W'(j_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) blk_mem[mem_wa] <= mem_wd;
    blk_rd_q <= blk_mem[unit_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_REINIT;
      need_q     <= '0;
      unit_q     <= '0;
      k_q        <= '0;
      count_q    <= CW'(1);
      ft_q       <= UW'(POOL_UNITS);
      found_q    <= 1'b0;
      exact_q    <= 1'b0;
      idx_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      cap_s_q    <= '0;
      cap_u_q    <= '0;
      ju_q       <= '0;
      end_q      <= '0;
      res_addr_q <= '0;
      res_st_q   <= ST_OK;
      m_valid_q  <= 1'b0;
      m_addr_q   <= '0;
      m_st_q     <= '0;
      m_free_q   <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != S_DONE) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q       <= in_op;
            res_addr_q <= '0;
            res_st_q   <= ST_OK;
            k_q        <= '0;
            found_q    <= 1'b0;
            exact_q    <= 1'b0;
            unique case (in_op)
              OP_REINIT: begin
                count_q <= CW'(1);
                ft_q    <= UW'(POOL_UNITS);
                state_q <= S_DONE;
              end
              OP_ALLOC: begin
                need_q  <= NEED_W'((17'(in_bytes) + 17'd35) >> 5);
                state_q <= S_SCAN;
              end
              OP_FREE: begin
                unit_q  <= SW'(in_unit);
                state_q <= in_unit_ok ? S_MRD : S_DONE;
              end
              OP_DEFRAG: begin
                i_q     <= '0;
                state_q <= (count_q != '0) ? S_DA : S_DONE;
              end
              default: ;
            endcase
          end
        end
        S_MRD: state_q <= S_FCHK;
        S_FCHK: state_q <= (blk_rd_q == '0) ? S_DONE : S_SCAN;
        S_SCAN: begin
          if (k_live) begin
            if (op_q == OP_ALLOC) begin
              if (!exact_q) begin
                if (VW'(h_units) == VW'(need_q)) begin
                  exact_q <= 1'b1;
                  idx_q   <= IW'(k_q);
                  cap_s_q <= h_start;
                end else if (VW'(h_units) > VW'(need_q) &&
                             (!found_q || h_units < cap_u_q)) begin
                  found_q <= 1'b1;
                  idx_q   <= IW'(k_q);
                  cap_s_q <= h_start;
                  cap_u_q <= h_units;
                end
              end
            end else if (!found_q &&
                         EW'(h_start) + EW'(h_units) == EW'(unit_q)) begin
              found_q <= 1'b1;
              idx_q   <= IW'(k_q);
              cap_u_q <= h_units;
            end
          end
          k_q <= k_q + CW'(1);
          if (k_last) state_q <= S_ACT;
        end
        S_ACT: begin
          state_q <= S_DONE;
          if (op_q == OP_ALLOC) begin
            if (alloc_ok) begin
              if (exact_q) count_q <= count_q - CW'(1);
              ft_q       <= (VW'(ft_q) >= VW'(need_q)) ? UW'(VW'(ft_q) - VW'(need_q)) : '0;
              res_addr_q <= 15'({alloc_s, 5'd4});
            end else begin
              res_st_q <= ST_NOFIT;
            end
          end else begin
            if (found_q) begin
              ft_q <= sat_add(ft_q, blk_rd_q);
            end else if (count_q < CW'(MAX_EXTENTS)) begin
              count_q <= count_q + CW'(1);
              ft_q    <= sat_add(ft_q, blk_rd_q);
            end else begin
              res_st_q <= ST_FULL;
            end
          end
        end
        S_DA: begin
          if (k_q == CW'(i_q)) begin
            end_q   <= EW'(h_start) + EW'(h_units);
            cap_u_q <= h_units;
          end
          if (k_last) begin
            k_q     <= '0;
            found_q <= 1'b0;
            state_q <= S_DB;
          end else begin
            k_q <= k_q + CW'(1);
          end
        end
        S_DB: begin
          if (k_live && k_q != CW'(i_q) && !found_q && EW'(h_start) == end_q) begin
            found_q <= 1'b1;
            j_q     <= IW'(k_q);
            ju_q    <= h_units;
          end
          if (k_last) begin
            k_q <= '0;
            if (found_q || (k_live && k_q != CW'(i_q) && EW'(h_start) == end_q)) begin
              state_q <= S_DMRG;
            end else if (CW'(i_q) + CW'(1) < count_q) begin
              i_q     <= i_q + IW'(1);
              state_q <= S_DA;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            k_q <= k_q + CW'(1);
          end
        end
        S_DMRG: state_q <= S_DDROP;
        S_DDROP: begin
          count_q <= count_q - CW'(1);
          i_q     <= '0;
          k_q     <= '0;
          state_q <= S_DA;
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_addr_q  <= res_addr_q;
            m_st_q    <= res_st_q;
            m_free_q  <= 11'(ft_q);
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_free_q, m_addr_q};
  assign m_axis_tuser  = m_st_q;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_EXTENTS))
    else $error("extent count above table size");
  a_free_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ft_q) <= 32'(POOL_UNITS))
    else $error("free total above pool size");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_st_q != ST_UNUSED))
    else $error("undefined status code");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("took a beat while working");
`endif

endmodule
